/* rtl/core/lrt_pkg.sv */
// Shared constants, codes and control types of the LRU replacement tracker.
`timescale 1ns / 1ps

package lrt_pkg;

	// Size of the tracker and of the identifiers it holds.
	localparam int CAPACITY = 16;
	localparam int ID_BITS  = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Widths of the channel fields.
	localparam int KIND_W   = 2;
	localparam int FRAME_W  = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// Operation codes.
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	// Control broadcast from the sequencer to every cell of the chain.
	typedef struct packed {
		logic apply;     // update the cells this cycle
		logic remove;    // close the gap at pos, shifting later cells down
		logic load_tail; // write key at the most recent end
		idx_t pos;       // position being removed
		cnt_t cnt;       // occupancy before the update
		id_t  key;       // identifier being compared or written
	} lrt_ctrl_t;

endpackage

/* rtl/core/lrt_req_if.sv */
// Request channel of the LRU replacement tracker: operation kind and frame identifier.
`timescale 1ns / 1ps

interface lrt_req_if;
	import lrt_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [FRAME_W-1:0]  frame_id;

	modport source (output valid, output kind, output frame_id, input ready);
	modport sink   (input valid, input kind, input frame_id, output ready);
endinterface

/* rtl/core/lrt_rsp_if.sv */
// Response channel of the LRU replacement tracker: status, victim and occupancy.
`timescale 1ns / 1ps

interface lrt_rsp_if;
	import lrt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FRAME_W-1:0]  victim_id;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, output status, output victim_id, output occupancy,
		input ready);
	modport sink   (input valid, input status, input victim_id, input occupancy,
		output ready);
endinterface

/* rtl/core/lrt_cell.sv */
// One slot of the recency chain: holds an identifier and its valid flag.
`timescale 1ns / 1ps

module lrt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  lrt_pkg::idx_t     idx,
	input  lrt_pkg::lrt_ctrl_t ctrl,
	input  lrt_pkg::id_t      next_id,
	output lrt_pkg::id_t      id,
	output logic              hit
);
	import lrt_pkg::*;

	id_t  id_q;
	logic valid_q;
	cnt_t idx_c;
	cnt_t idx_p1;
	logic at_or_above_pos;

	// Position of this cell in occupancy terms.
	assign idx_c           = cnt_t'(idx);
	assign idx_p1          = idx_c + cnt_t'(1);
	assign at_or_above_pos = (idx >= ctrl.pos);

	// Match against the broadcast key.
	assign hit   = valid_q && (id_q == ctrl.key);
	assign id    = id_q;

	// Identifier: shift down from the neighbor or load the key at the tail.
	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			if (ctrl.remove) begin
				if (at_or_above_pos && (idx_p1 < ctrl.cnt)) begin
					id_q <= next_id;
				end else if ((idx_p1 == ctrl.cnt) && ctrl.load_tail) begin
					id_q <= ctrl.key;
				end
			end else if (ctrl.load_tail && (idx_c == ctrl.cnt)) begin
				id_q <= ctrl.key;
			end
		end
	end

	// Valid flag: the tail cell drops on a removal that loads no key, the next free cell fills on an insert.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.apply) begin
			if (ctrl.remove) begin
				if ((idx_p1 == ctrl.cnt) && !ctrl.load_tail) begin
					valid_q <= 1'b0;
				end
			end else if (ctrl.load_tail && (idx_c == ctrl.cnt)) begin
				valid_q <= 1'b1;
			end
		end
	end
endmodule

/* rtl/core/lru_replacement_tracker_core.sv */
// Top level of the LRU replacement tracker: sequencer, chain of slot cells and response register.
`timescale 1ns / 1ps

// The tracker keeps up to CAPACITY frame identifiers ordered by recency, the
// least recent in cell 0. Requests arrive as beats on the req channel (kind,
// frame_id); each request yields exactly one beat on the rsp channel (status,
// victim_id, occupancy), in request order.
// Kinds: insert or touch moves or adds the identifier to the most recent end,
// evict removes and returns the least recent one, erase removes a given one.
// A request passes through the states IDLE, in which it is accepted, CMP, in
// which every cell compares its identifier with the key and the hit position is
// encoded, and APPLY, in which the chain shifts and the response register loads.
// A new request is accepted only after the previous one has left APPLY; the
// compare-then-shift sequence over the cell chain sets that limit.
// The response register lets the next request be accepted while a response
// still waits. If the receiver stalls, the update of the following request is
// held until the response register frees up, and then no further request is
// accepted until that happens.
// Reset clears all valid flags, the occupancy count and the sequencer; no
// clearing pass is needed, so a request is accepted right after reset.

module lru_replacement_tracker_core (
	input  logic      clk,
	input  logic      arst_n,
	lrt_req_if.sink   req,
	lrt_rsp_if.source rsp
);
	import lrt_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CMP   = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	logic [1:0]          state_q;
	logic [KIND_W-1:0]   kind_s1;
	id_t                 key_s1;
	idx_t                pos_q;
	logic                found_q;
	cnt_t                cnt_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [FRAME_W-1:0]  victim_q;
	logic [OCC_W-1:0]    occ_q;

	lrt_ctrl_t           ctrl;
	id_t                 cell_id   [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;

	idx_t                hit_pos;
	logic                rsp_free;
	logic                do_apply;
	logic                op_remove;
	logic                op_load;
	idx_t                op_pos;
	cnt_t                cnt_next;
	logic [STATUS_W-1:0] status_next;
	id_t                 victim_next;

	assign req.ready = (state_q == ST_IDLE);
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign do_apply  = (state_q == ST_APPLY) && rsp_free;

	// Encode the hit position; identifiers are unique, so at most one cell hits.
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_hit[i]) begin
				hit_pos = hit_pos | idx_t'(i);
			end
		end
	end

	// Decide the update and the result from the registered compare outcome.
	always_comb begin
		op_remove   = 1'b0;
		op_load     = 1'b0;
		op_pos      = pos_q;
		cnt_next    = cnt_q;
		status_next = STATUS_OK;
		victim_next = '0;
		unique case (kind_s1)
			KIND_INSERT: begin
				if (found_q) begin
					op_remove = 1'b1;
					op_load   = 1'b1;
				end else if (cnt_q == cnt_t'(CAPACITY)) begin
					status_next = STATUS_FULL;
				end else begin
					op_load  = 1'b1;
					cnt_next = cnt_q + cnt_t'(1);
				end
			end
			KIND_EVICT: begin
				if (cnt_q == '0) begin
					status_next = STATUS_EMPTY;
				end else begin
					op_remove   = 1'b1;
					op_pos      = '0;
					victim_next = cell_id[0];
					cnt_next    = cnt_q - cnt_t'(1);
				end
			end
			KIND_ERASE: begin
				if (found_q) begin
					op_remove = 1'b1;
					cnt_next  = cnt_q - cnt_t'(1);
				end else begin
					status_next = STATUS_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	// Control broadcast to the chain.
	assign ctrl.apply     = do_apply;
	assign ctrl.remove    = op_remove;
	assign ctrl.load_tail = op_load;
	assign ctrl.pos       = op_pos;
	assign ctrl.cnt       = cnt_q;
	assign ctrl.key       = key_s1;

	// Chain of cells; each one takes the identifier of its upper neighbor on a shift.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		id_t nb_id;
		if (g == CAPACITY - 1) begin : g_last
			assign nb_id = '0;
		end else begin : g_mid
			assign nb_id = cell_id[g + 1];
		end
		lrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (idx_t'(g)),
			.ctrl    (ctrl),
			.next_id (nb_id),
			.id      (cell_id[g]),
			.hit     (cell_hit[g])
		);
	end

	// Request capture and compare result.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1 <= req.kind;
			key_s1  <= req.frame_id[ID_BITS-1:0];
		end
		if (state_q == ST_CMP) begin
			pos_q   <= hit_pos;
			found_q <= |cell_hit;
		end
	end

	// Sequencer and occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
						cnt_q   <= cnt_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (do_apply) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_apply) begin
			status_q <= status_next;
			victim_q <= FRAME_W'(victim_next);
			occ_q    <= OCC_W'(cnt_next);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.victim_id = victim_q;
	assign rsp.occupancy = occ_q;
endmodule
